/* hdl/spp_pkg.sv */
// Package for the sparse pixel packetizer: packet marks, header layout and
// input command codes. It has no dependencies.
`default_nettype none

package spp_pkg;

  // Packet marks: a data packet opens with 'B', a terminal packet is 'C'.
  localparam logic [7:0] DATA_MARK = 8'h42;
  localparam logic [7:0] TERM_MARK = 8'h43;

  // Packet layout sizes in bytes.
  localparam int HDR_BYTES   = 4;
  localparam int ENTRY_BYTES = 3;

  // Width of the linear pixel index and of one buffered entry.
  localparam int POS_W   = 16;
  localparam int ENTRY_W = 24;

  // Input command codes carried in in_tuser.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_EOF   = 1'b1;

  // Header byte positions.
  localparam logic [1:0] HDR_MARK   = 2'd0;
  localparam logic [1:0] HDR_ID_LO  = 2'd1;
  localparam logic [1:0] HDR_ID_HI  = 2'd2;
  localparam logic [1:0] HDR_COUNT  = 2'd3;

  // Byte positions inside one entry.
  localparam logic [1:0] ENT_IDX_LO = 2'd0;
  localparam logic [1:0] ENT_IDX_HI = 2'd1;
  localparam logic [1:0] ENT_VALUE  = 2'd2;

  // One result byte with its flags.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
    logic       run_end;
  } out_item_t;

endpackage

`default_nettype wire

/* hdl/sparse_pixel_packetizer.sv */
// A packet's first byte passes the state register, then the output register.
// A pixel that sends nothing leaves the block idle; a data packet streams
// 4 + 3 * entries bytes at one byte per cycle from the entry RAM while not
// stalled by out_tready, a terminal packet one byte. New input is taken once
// the last byte is in the output register. Synchronous reset (rst_n low)
// clears state, count, position, eof, image id and output valid, not the RAM.
`default_nettype none

module sparse_pixel_packetizer
  import spp_pkg::*;
#(
  parameter int PACKET_FILL_LIMIT = 61,
  parameter int FRAME_SIDE        = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write channel: image_id.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] pixel_value, [8] source_empty
  input  wire logic        in_tuser,   // [0] cmd
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] data_byte
  output logic             out_tlast,  // packet_end
  output logic             out_tuser   // [0] run_end
);

  localparam int ENTRIES      = ((PACKET_FILL_LIMIT - HDR_BYTES) / ENTRY_BYTES) + 1;
  localparam int CNT_W        = $clog2(ENTRIES + 1);
  localparam int ADDR_W       = $clog2(ENTRIES);
  localparam int FRAME_PIXELS = FRAME_SIDE * FRAME_SIDE;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HDR  = 2'd1;
  localparam logic [1:0] S_ENT  = 2'd2;
  localparam logic [1:0] S_TERM = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [15:0]        image_id_r, image_id_nxt;
  logic               eof_r, eof_nxt;
  logic [1:0]         hdr_sel_r, hdr_sel_nxt;
  logic [1:0]         byte_sel_r, byte_sel_nxt;
  logic [ADDR_W-1:0]  ent_idx_r, ent_idx_nxt;
  logic [ENTRY_W-1:0] ent_r, ent_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic               in_accept;
  logic               in_cmd;
  logic [7:0]         in_pixel;
  logic               in_empty;
  logic               load;
  logic               last_entry;
  logic [ADDR_W-1:0]  last_idx;

  logic               ram_wr_en;
  logic [ADDR_W-1:0]  ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [ADDR_W-1:0]  ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;

  assign in_cmd    = in_tuser;
  assign in_pixel  = in_tdata[7:0];
  assign in_empty  = in_tdata[8];
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // The output register takes a new byte when it is empty or being drained.
  assign load = !out_valid_r || out_tready;

  assign last_idx   = ADDR_W'(count_r - CNT_W'(1));
  assign last_entry = (ent_idx_r == last_idx);

  // Entry store: written on a nonzero pixel, read ahead during emission.
  assign ram_wr_en   = in_accept && (in_cmd == CMD_PIXEL) && (in_pixel != 8'd0) &&
                       (count_r < CNT_W'(ENTRIES));
  assign ram_wr_addr = count_r[ADDR_W-1:0];
  assign ram_wr_data = {in_pixel, pos_r};
  assign ram_rd_en   = (state_r == S_HDR) ||
                       ((state_r == S_ENT) && load && (byte_sel_r == ENT_IDX_LO) &&
                        !last_entry);
  assign ram_rd_addr = (state_r == S_HDR) ? '0 : ent_idx_r + ADDR_W'(1);

  spp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Sequencer, counters and the next output byte.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    image_id_nxt  = image_id_r;
    eof_nxt       = eof_r;
    hdr_sel_nxt   = hdr_sel_r;
    byte_sel_nxt  = byte_sel_r;
    ent_idx_nxt   = ent_idx_r;
    ent_nxt       = ent_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;

    if (cfg_valid && cfg_ready) begin
      image_id_nxt = cfg_data;
    end

    if (load) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_cmd == CMD_PIXEL) begin
            if (pos_r == POS_W'(FRAME_PIXELS - 1)) begin
              pos_nxt = '0;
            end else begin
              pos_nxt = pos_r + POS_W'(1);
            end
            if (ram_wr_en) begin
              count_nxt = count_r + CNT_W'(1);
              if (count_r + CNT_W'(1) == CNT_W'(ENTRIES)) begin
                eof_nxt     = 1'b0;
                hdr_sel_nxt = HDR_MARK;
                state_nxt   = S_HDR;
              end
            end
          end else begin
            pos_nxt = '0;
            eof_nxt = 1'b1;
            if (in_empty) begin
              count_nxt = '0;
            end else if (count_r != '0) begin
              hdr_sel_nxt = HDR_MARK;
              state_nxt   = S_HDR;
            end else begin
              state_nxt = S_TERM;
            end
          end
        end
      end

      S_HDR: begin
        if (load) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.packet_end = 1'b0;
          out_item_nxt.run_end    = 1'b0;
          unique case (hdr_sel_r)
            HDR_MARK:  out_item_nxt.data_byte = DATA_MARK;
            HDR_ID_LO: out_item_nxt.data_byte = image_id_r[7:0];
            HDR_ID_HI: out_item_nxt.data_byte = image_id_r[15:8];
            default:   out_item_nxt.data_byte = 8'(count_r);
          endcase
          hdr_sel_nxt = hdr_sel_r + 2'd1;
          if (hdr_sel_r == HDR_COUNT) begin
            ent_idx_nxt  = '0;
            byte_sel_nxt = ENT_IDX_LO;
            state_nxt    = S_ENT;
          end
        end
      end

      S_ENT: begin
        if (load) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.packet_end = 1'b0;
          out_item_nxt.run_end    = 1'b0;
          unique case (byte_sel_r)
            ENT_IDX_LO: begin
              out_item_nxt.data_byte = ram_rd_data[7:0];
              ent_nxt                = ram_rd_data;
            end
            ENT_IDX_HI: out_item_nxt.data_byte = ent_r[15:8];
            default:    out_item_nxt.data_byte = ent_r[23:16];
          endcase
          if (byte_sel_r == ENT_VALUE) begin
            byte_sel_nxt = ENT_IDX_LO;
            ent_idx_nxt  = ent_idx_r + ADDR_W'(1);
            if (last_entry) begin
              // Last byte of the data packet; the buffer empties here.
              out_item_nxt.packet_end = 1'b1;
              out_item_nxt.run_end    = !eof_r;
              count_nxt               = '0;
              state_nxt               = eof_r ? S_TERM : S_IDLE;
            end
          end else begin
            byte_sel_nxt = byte_sel_r + 2'd1;
          end
        end
      end

      default: begin
        // Terminal packet closes the frame.
        if (load) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.data_byte  = TERM_MARK;
          out_item_nxt.packet_end = 1'b1;
          out_item_nxt.run_end    = 1'b1;
          count_nxt               = '0;
          state_nxt               = S_IDLE;
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pos_r       <= '0;
      image_id_r  <= '0;
      eof_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      image_id_r  <= image_id_nxt;
      eof_r       <= eof_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and emission position registers.
  always_ff @(posedge clk) begin
    hdr_sel_r  <= hdr_sel_nxt;
    byte_sel_r <= byte_sel_nxt;
    ent_idx_r  <= ent_idx_nxt;
    ent_r      <= ent_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r.data_byte;
  assign out_tlast  = out_item_r.packet_end;
  assign out_tuser  = out_item_r.run_end;

endmodule

`default_nettype wire

/* hdl/spp_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; contents are undefined until written.
`default_nettype none

module spp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 20
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; the data holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* verif/sparse_pixel_packetizer_tb.sv */
// Self-checking testbench for the sparse pixel packetizer: a cycle-free predictor builds the
// expected packet bytes for every accepted pixel or end-of-frame transaction.
// Depends on spp_pkg and the sparse_pixel_packetizer RTL only.

module sparse_pixel_packetizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spp_pkg::*;

  localparam int FILL_LIMIT   = 61;
  localparam int SIDE         = 256;
  localparam int ENTRIES      = (FILL_LIMIT - HDR_BYTES) / ENTRY_BYTES + 1;
  localparam int FRAME_PIXELS = SIDE * SIDE;
  localparam int MAX_BURST    = 64;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_LIMIT = 60;

  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel_value;
    logic       source_empty;
  } frame_item_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_ONE_IN_FOUR,
    READY_MOSTLY
  } ready_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  sparse_pixel_packetizer #(
    .PACKET_FILL_LIMIT(FILL_LIMIT),
    .FRAME_SIDE       (SIDE)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  // Stimulus and expectation stores.
  frame_item_t frame_items[$];
  out_item_t   expected_bytes[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          in_taken = 1'b0;
  logic        hold_req = 1'b0;

  // Predictor state: image id, entry buffer, entry count and pixel position.
  logic [15:0]        img_id = '0;
  logic [ENTRY_W-1:0] entry_ram [ENTRIES];
  logic [4:0]         entry_cnt = '0;
  logic [POS_W-1:0]   pix_pos = '0;

  // Bytes caused by the transaction being predicted.
  logic [7:0] burst_byte [MAX_BURST];
  logic       burst_last [MAX_BURST];
  int         burst_n;

  out_item_t want_byte;

  function automatic void add_byte(input logic [7:0] b, input logic last);
    burst_byte[burst_n] = b;
    burst_last[burst_n] = last;
    burst_n++;
  endfunction

  // Send the buffered entries as one data packet and empty the buffer.
  function automatic void flush_entries();
    logic [4:0]         cnt;
    logic [ENTRY_W-1:0] e;
    cnt = (entry_cnt > ENTRIES) ? 5'(ENTRIES) : entry_cnt;
    add_byte(DATA_MARK, 1'b0);
    add_byte(img_id[7:0], 1'b0);
    add_byte(img_id[15:8], 1'b0);
    add_byte(8'(cnt), cnt == 0);
    for (int k = 0; k < int'(cnt); k++) begin
      e = entry_ram[k];
      add_byte(e[7:0], 1'b0);
      add_byte(e[15:8], 1'b0);
      add_byte(e[23:16], k == int'(cnt) - 1);
    end
    entry_cnt = '0;
  endfunction

  // Work out the bytes one accepted transaction causes and queue them.
  function automatic void packetize_item(input frame_item_t it);
    burst_n = 0;
    if (it.cmd == CMD_PIXEL) begin
      if (it.pixel_value != 8'd0) begin
        if (entry_cnt < ENTRIES) begin
          entry_ram[entry_cnt] = {it.pixel_value, pix_pos};
          entry_cnt++;
        end
        if (entry_cnt >= ENTRIES) flush_entries();
      end
      pix_pos = 16'((32'(pix_pos) + 1) % FRAME_PIXELS);
    end else begin
      // An empty source frame drops the buffer and sends nothing.
      if (!it.source_empty) begin
        if (entry_cnt > 0) flush_entries();
        add_byte(TERM_MARK, 1'b1);
      end
      entry_cnt = '0;
      pix_pos = '0;
    end
    for (int k = 0; k < burst_n; k++) begin
      expected_bytes.push_back(out_item_t'({burst_byte[k], burst_last[k], k == burst_n - 1}));
    end
  endfunction

  function automatic void report_mismatch(input string what, input logic [7:0] want,
                                          input logic [7:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
    end
  endfunction

  function automatic void schedule_item(input logic cmd, input logic [7:0] pix,
                                        input logic empty);
    frame_items.push_back(frame_item_t'({cmd, pix, empty}));
  endfunction

  // Random frames: mostly well-formed pixel runs of varying density, some bare
  // end-of-frame transactions, and now and then an empty source frame.
  function automatic void add_random_frames(input int n_items);
    int         done_items;
    int         len;
    int         density;
    logic [7:0] v;
    done_items = 0;
    while (done_items < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 45);
      case ($urandom_range(0, 2))
        0: density = 15;
        1: density = 60;
        default: density = 95;
      endcase
      for (int p = 0; p < len; p++) begin
        if ($urandom_range(0, 99) < density) begin
          case ($urandom_range(0, 9))
            0: v = 8'hFF;
            1: v = 8'h01;
            default: v = 8'($urandom_range(1, 255));
          endcase
        end else begin
          v = 8'h00;
        end
        schedule_item(CMD_PIXEL, v, 1'($urandom_range(0, 1)));
      end
      schedule_item(CMD_EOF, 8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
      done_items += len + 1;
    end
  endfunction

  // Clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sparse_pixel_packetizer: mismatch");
      $finish;
    end
  end

  // Monitor: predict on accepted transactions and check every result byte.
  always @(posedge clk) begin
    in_taken = rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) img_id = cfg_data;
      if (in_taken) packetize_item(frame_item_t'({in_tuser, in_tdata[7:0], in_tdata[8]}));
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected byte", 8'h00, out_tdata);
        end else begin
          want_byte = expected_bytes.pop_front();
          if (out_tdata !== want_byte.data_byte)
            report_mismatch("data_byte", want_byte.data_byte, out_tdata);
          if (out_tlast !== want_byte.packet_end)
            report_mismatch("packet_end", 8'(want_byte.packet_end), 8'(out_tlast));
          if (out_tuser !== want_byte.run_end)
            report_mismatch("run_end", 8'(want_byte.run_end), 8'(out_tuser));
        end
      end
    end
  end

  // Driver: bursts of transactions from the pending queue with random gaps.
  int burst_left = 0;
  int gap_left = 0;
  frame_item_t next_item;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (frame_items.size() > 0) begin
        next_item = frame_items.pop_front();
        in_tuser  <= next_item.cmd;
        in_tdata  <= {7'b0, next_item.source_empty, next_item.pixel_value};
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 9) == 0) gap_left = $urandom_range(20, 40);
          else if ($urandom_range(0, 1) == 0) gap_left = 0;
          else gap_left = $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switches between stall patterns, plus one long hold-off once
  // requested, so the block backs up and stops taking input.
  ready_mode_t ready_mode = READY_ALWAYS;
  int          mode_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  logic [1:0]  ready_phase = '0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done && out_tvalid) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 200);
      end else begin
        mode_left--;
      end
      ready_phase++;
      case (ready_mode)
        READY_ALWAYS:      out_tready <= 1'b1;
        READY_RANDOM:      out_tready <= 1'($urandom_range(0, 1));
        READY_ONE_IN_FOUR: out_tready <= (ready_phase == 2'd0);
        default:           out_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Write the image id while the block is idle.
  task automatic write_image_id(input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every transaction is taken and every byte has come out.
  task automatic wait_idle();
    while (frame_items.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with the all-ones image id.
    write_image_id(16'hFFFF);
    // End of frame with nothing buffered sends only the terminal packet.
    schedule_item(CMD_EOF, 8'h00, 1'b0);
    // Empty source frame sends nothing.
    schedule_item(CMD_EOF, 8'h00, 1'b1);
    // A zero pixel is dropped but advances the position.
    schedule_item(CMD_PIXEL, 8'h00, 1'b0);
    schedule_item(CMD_PIXEL, 8'hFF, 1'b0);
    schedule_item(CMD_PIXEL, 8'h01, 1'b1);
    schedule_item(CMD_PIXEL, 8'h80, 1'b0);
    // Partial packet flush; the pixel value at end of frame is ignored.
    schedule_item(CMD_EOF, 8'hAB, 1'b0);
    // Buffered entries are dropped when the source frame was empty.
    schedule_item(CMD_PIXEL, 8'h5A, 1'b0);
    schedule_item(CMD_EOF, 8'hFF, 1'b1);
    // A full packet of entries goes out on its own.
    for (int k = 0; k < ENTRIES; k++) begin
      schedule_item(CMD_PIXEL, (k == 0) ? 8'hFF : 8'(k), 1'b1);
    end
    schedule_item(CMD_EOF, 8'h00, 1'b0);
    wait_idle();

    write_image_id(16'h0000);
    add_random_frames(25);
    wait_idle();

    // Long receiver hold-off while the sender keeps offering.
    write_image_id(16'($urandom_range(0, 65535)));
    hold_req = 1'b1;
    add_random_frames(50);
    wait_idle();

    write_image_id(16'($urandom_range(0, 65535)));
    add_random_frames(30);
    wait_idle();

    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("sparse_pixel_packetizer: match");
    end else begin
      $display("sparse_pixel_packetizer: mismatch");
    end
    $finish;
  end

endmodule
